// ===== src/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared definitions
// Field widths, branch codes and the side data that travels with the root.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int ELEM_W        = 16;
    localparam int MAG_W         = 17;
    localparam int QUO_W         = 17;
    localparam int OUT_W         = 16;

    // Component taken from the square root.
    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_Z = 2'd2;
    localparam logic [1:0] SEL_W = 2'd3;

    typedef struct packed {
        logic [1:0]       sel;
        logic [2:0]       neg;
        logic [MAG_W-1:0] mag_a;
        logic [MAG_W-1:0] mag_b;
        logic [MAG_W-1:0] mag_c;
    } side_t;

endpackage

// ===== src/rmq_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage; side data and a valid bit travel alongside.
// ----------------------------------------------------------------------------
module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int RAD_W = 33
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [RAD_W-1:0]           radicand,
    input  side_t                      in_side,
    output logic                       out_valid,
    output logic [(RAD_W+1)/2-1:0]     root,
    output side_t                      out_side
);

    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int PAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    logic [ROOT_W-1:0] vld_reg;
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] res_reg  [ROOT_W];
    logic [PAD_W-1:0]  rad_reg  [ROOT_W];
    side_t             side_reg [ROOT_W];

    logic [REM_W-1:0]  rem_in   [ROOT_W];
    logic [ROOT_W-1:0] res_in   [ROOT_W];
    logic [PAD_W-1:0]  rad_in   [ROOT_W];
    logic [REM_W-1:0]  shl      [ROOT_W];
    logic [REM_W-1:0]  trial    [ROOT_W];
    logic [REM_W-1:0]  rem_next [ROOT_W];
    logic [ROOT_W-1:0] res_next [ROOT_W];

    generate
        for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
            if (g == 0) begin : g_first
                assign rem_in[g] = '0;
                assign res_in[g] = '0;
                assign rad_in[g] = PAD_W'(radicand);
            end
            else begin : g_rest
                assign rem_in[g] = rem_reg[g-1];
                assign res_in[g] = res_reg[g-1];
                assign rad_in[g] = rad_reg[g-1];
            end

            // Remainder stays below 2*root+1, so its top two bits are free.
            assign shl[g]   = {rem_in[g][REM_W-3:0], rad_in[g][PAD_W-1 -: 2]};
            assign trial[g] = {1'b0, res_in[g], 2'b01};

            always_comb
            begin
                if (shl[g] >= trial[g])
                begin
                    rem_next[g] = shl[g] - trial[g];
                    res_next[g] = {res_in[g][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[g] = shl[g];
                    res_next[g] = {res_in[g][ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g] <= 1'b0;
                end
                else
                begin
                    vld_reg[g] <= (g == 0) ? in_valid : vld_reg[(g == 0) ? 0 : g-1];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g]  <= rem_next[g];
                res_reg[g]  <= res_next[g];
                rad_reg[g]  <= rad_in[g] << 2;
                side_reg[g] <= (g == 0) ? in_side : side_reg[(g == 0) ? 0 : g-1];
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = res_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== src/rmq_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Computes mag * ONE / (2 * root), rounded half away from zero, signed and
// saturated to 16 bits. One quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ROOT_W    = 17
)
(
    input  logic                    clk,
    input  logic [MAG_W-1:0]        mag,
    input  logic                    neg,
    input  logic [ROOT_W-1:0]       root,
    output logic signed [OUT_W-1:0] quo
);

    localparam int N_W   = MAG_W + FRAC_BITS + 2;
    localparam int D_W   = ROOT_W + 2;
    localparam int CMP_W = ((N_W > D_W + QUO_W) ? N_W : D_W + QUO_W) + 1;
    localparam logic [QUO_W-1:0] POS_MAX = QUO_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [QUO_W-1:0] NEG_MAX = QUO_W'(1 << (OUT_W - 1));

    // Index 0 holds the prepared operands; index k holds k quotient bits.
    logic [CMP_W-1:0] rem_reg  [QUO_W+1];
    logic [CMP_W-1:0] den_reg  [QUO_W+1];
    logic [QUO_W-1:0] q_reg    [QUO_W+1];
    logic             neg_reg  [QUO_W+1];
    logic             zero_reg [QUO_W+1];
    logic             ovf_reg  [QUO_W+1];
    logic signed [OUT_W-1:0] quo_reg;

    logic [CMP_W-1:0] num_w;
    logic [CMP_W-1:0] den_w;

    // (2*mag*ONE + 2*root) / (4*root) gives the rounded quotient.
    assign num_w = (CMP_W'(mag) << (FRAC_BITS + 1)) + (CMP_W'(root) << 1);
    assign den_w = CMP_W'(root) << 2;

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num_w;
        den_reg[0]  <= den_w;
        q_reg[0]    <= '0;
        neg_reg[0]  <= neg;
        zero_reg[0] <= (root == '0);
        ovf_reg[0]  <= (num_w >= (den_w << QUO_W));
    end

    generate
        for (genvar k = 1; k <= QUO_W; k++) begin : g_bit
            logic [CMP_W-1:0] shifted;
            logic             take;

            assign shifted = den_reg[k-1] << (QUO_W - k);
            assign take    = (rem_reg[k-1] >= shifted);

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= take ? (rem_reg[k-1] - shifted) : rem_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                q_reg[k]    <= {q_reg[k-1][QUO_W-2:0], take};
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        priority if (zero_reg[QUO_W])
        begin
            quo_reg <= '0;
        end
        else if (neg_reg[QUO_W])
        begin
            if (ovf_reg[QUO_W] || (q_reg[QUO_W] > NEG_MAX))
                quo_reg <= OUT_W'(NEG_MAX);
            else
                quo_reg <= OUT_W'(-q_reg[QUO_W]);
        end
        else
        begin
            if (ovf_reg[QUO_W] || (q_reg[QUO_W] > POS_MAX))
                quo_reg <= OUT_W'(POS_MAX);
            else
                quo_reg <= OUT_W'(q_reg[QUO_W]);
        end
    end

    assign quo = quo_reg;

endmodule

// ===== src/rotation_matrix_to_quaternion_top.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion (Shepperd method), top level
//
//   Channel   Handshake        Payload
//   input     start / busy     m00 .. m22, signed Q2.14
//   result    done (strobe)    quat_x, quat_y, quat_z, quat_w, signed Q2.14
//
// A transaction is accepted every cycle; busy is always low. Each result
// passes the stage-1 register, the square root (one bit per stage), the
// dividers (setup, 17 quotient bits, saturation) and the output register.
// Reset clears only the valid bits. The receiver cannot stall, so the
// pipeline never stops.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [ELEM_W-1:0] m00,
    input  logic signed [ELEM_W-1:0] m01,
    input  logic signed [ELEM_W-1:0] m02,
    input  logic signed [ELEM_W-1:0] m10,
    input  logic signed [ELEM_W-1:0] m11,
    input  logic signed [ELEM_W-1:0] m12,
    input  logic signed [ELEM_W-1:0] m20,
    input  logic signed [ELEM_W-1:0] m21,
    input  logic signed [ELEM_W-1:0] m22,
    output logic                     done,
    output logic signed [OUT_W-1:0]  quat_x,
    output logic signed [OUT_W-1:0]  quat_y,
    output logic signed [OUT_W-1:0]  quat_z,
    output logic signed [OUT_W-1:0]  quat_w
);

    localparam int ARG_W  = (FRAC_BITS >= 17) ? FRAC_BITS + 1 : 18;
    localparam int SUM_W  = ARG_W + 2;
    localparam int RAD_W  = ARG_W + FRAC_BITS;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int DLY    = QUO_W + 2;
    localparam int LAT    = ROOT_W + QUO_W + 4;
    localparam logic [ROOT_W:0] HALF_MAX = (ROOT_W + 1)'((1 << (OUT_W - 1)) - 1);

    function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W-1:0] v);
        mag_of = v[MAG_W-1] ? (~v + 1'b1) : v;
    endfunction

    // ---------------- Stage 1: branch, root argument, numerators ----------
    logic signed [SUM_W-1:0] e00, e11, e22, one_s, trace, arg_s;
    logic        [1:0]       sel_w;
    logic        [MAG_W-1:0] n_a, n_b, n_c;
    logic        [MAG_W-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;

    assign e00   = SUM_W'(m00);
    assign e11   = SUM_W'(m11);
    assign e22   = SUM_W'(m22);
    assign one_s = SUM_W'(1) << FRAC_BITS;
    assign trace = e00 + e11 + e22;

    assign d21_12 = MAG_W'(m21) - MAG_W'(m12);
    assign d02_20 = MAG_W'(m02) - MAG_W'(m20);
    assign d10_01 = MAG_W'(m10) - MAG_W'(m01);
    assign s01_10 = MAG_W'(m01) + MAG_W'(m10);
    assign s02_20 = MAG_W'(m02) + MAG_W'(m20);
    assign s12_21 = MAG_W'(m12) + MAG_W'(m21);

    always_comb
    begin
        priority if (trace > 0)
        begin
            sel_w = SEL_W;
            arg_s = trace + one_s;
        end
        else if ((m00 > m11) && (m00 > m22))
        begin
            sel_w = SEL_X;
            arg_s = one_s + e00 - e11 - e22;
        end
        else if (m11 > m22)
        begin
            sel_w = SEL_Y;
            arg_s = one_s + e11 - e00 - e22;
        end
        else
        begin
            sel_w = SEL_Z;
            arg_s = one_s + e22 - e00 - e11;
        end
    end

    // Lane a always feeds w unless w itself comes from the root.
    always_comb
    begin
        unique case (sel_w)
            SEL_W:
            begin
                n_a = d21_12; n_b = d02_20; n_c = d10_01;
            end
            SEL_X:
            begin
                n_a = d21_12; n_b = s01_10; n_c = s02_20;
            end
            SEL_Y:
            begin
                n_a = d02_20; n_b = s01_10; n_c = s12_21;
            end
            default:
            begin
                n_a = d10_01; n_b = s02_20; n_c = s12_21;
            end
        endcase
    end

    logic             s1_vld_reg;
    logic [RAD_W-1:0] s1_rad_reg;
    side_t            s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_rad_reg        <= arg_s[SUM_W-1] ? '0
                             : (RAD_W'(arg_s[ARG_W-1:0]) << FRAC_BITS);
        s1_side_reg.sel   <= sel_w;
        s1_side_reg.neg   <= {n_a[MAG_W-1], n_b[MAG_W-1], n_c[MAG_W-1]};
        s1_side_reg.mag_a <= mag_of(n_a);
        s1_side_reg.mag_b <= mag_of(n_b);
        s1_side_reg.mag_c <= mag_of(n_c);
    end

    // ---------------- Square root -----------------------------------------
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;

    rmq_sqrt #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_vld_reg),
        .radicand  (s1_rad_reg),
        .in_side   (s1_side_reg),
        .out_valid (sq_vld),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // ---------------- Dividers --------------------------------------------
    logic signed [OUT_W-1:0] q_a, q_b, q_c;

    rmq_div #(.FRAC_BITS(FRAC_BITS), .ROOT_W(ROOT_W)) u_div_a (
        .clk (clk), .mag (sq_side.mag_a), .neg (sq_side.neg[2]),
        .root (sq_root), .quo (q_a)
    );
    rmq_div #(.FRAC_BITS(FRAC_BITS), .ROOT_W(ROOT_W)) u_div_b (
        .clk (clk), .mag (sq_side.mag_b), .neg (sq_side.neg[1]),
        .root (sq_root), .quo (q_b)
    );
    rmq_div #(.FRAC_BITS(FRAC_BITS), .ROOT_W(ROOT_W)) u_div_c (
        .clk (clk), .mag (sq_side.mag_c), .neg (sq_side.neg[0]),
        .root (sq_root), .quo (q_c)
    );

    // Half root, rounded up and saturated, waits alongside the dividers.
    logic [ROOT_W:0]         half_w;
    logic signed [OUT_W-1:0] half_sat;

    assign half_w   = ((ROOT_W + 1)'(sq_root) + 1'b1) >> 1;
    assign half_sat = (half_w > HALF_MAX) ? OUT_W'(HALF_MAX) : OUT_W'(half_w);

    logic [DLY-1:0]          dl_vld_reg;
    logic [1:0]              dl_sel_reg  [DLY];
    logic signed [OUT_W-1:0] dl_half_reg [DLY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dl_vld_reg <= '0;
        else
            dl_vld_reg <= {dl_vld_reg[DLY-2:0], sq_vld};
    end

    always_ff @(posedge clk)
    begin
        dl_sel_reg[0]  <= sq_side.sel;
        dl_half_reg[0] <= half_sat;
        for (int i = 1; i < DLY; i++)
        begin
            dl_sel_reg[i]  <= dl_sel_reg[i-1];
            dl_half_reg[i] <= dl_half_reg[i-1];
        end
    end

    // ---------------- Output register -------------------------------------
    logic                    done_reg;
    logic signed [OUT_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [OUT_W-1:0] qx_next, qy_next, qz_next, qw_next;
    logic signed [OUT_W-1:0] hv;

    assign hv = dl_half_reg[DLY-1];

    always_comb
    begin
        unique case (dl_sel_reg[DLY-1])
            SEL_W:
            begin
                qx_next = q_a; qy_next = q_b; qz_next = q_c; qw_next = hv;
            end
            SEL_X:
            begin
                qx_next = hv; qy_next = q_b; qz_next = q_c; qw_next = q_a;
            end
            SEL_Y:
            begin
                qx_next = q_b; qy_next = hv; qz_next = q_c; qw_next = q_a;
            end
            default:
            begin
                qx_next = q_b; qy_next = q_c; qz_next = hv; qw_next = q_a;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dl_vld_reg[DLY-1];
    end

    always_ff @(posedge clk)
    begin
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        qz_reg <= qz_next;
        qw_reg <= qw_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign quat_x = qx_reg;
    assign quat_y = qy_reg;
    assign quat_z = qz_reg;
    assign quat_w = qw_reg;

`ifndef SYNTHESIS
    // Every accepted transaction produces exactly one result on done.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted transaction produced no result");

    a_result_caused: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching transaction");

    // The root-derived component is never negative.
    a_half_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        dl_vld_reg[DLY-1] |-> !hv[OUT_W-1])
        else $error("root component went negative");
`endif

endmodule

// ===== tb/rotation_matrix_to_quaternion_top_tb.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion testbench
// Drives directed and random matrices through the command port in bursts and
// compares every quaternion strobe with set values or a fixed-point predictor.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top_tb;
    import rmq_pkg::*;

    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int N_RANDOM = 1630;
    localparam int LATENCY  = 60;
    localparam int WD_LIMIT = 2000;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [OUT_W-1:0]  comp_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
        comp_t w;
    } quat_t;

    typedef struct {
        elem_t m [9];
        bit    has_exp;
        quat_t exp_q;
    } row_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic  done;
    comp_t quat_x, quat_y, quat_z, quat_w;

    quat_t quat_queue [$];
    row_t  dir [$];
    int    error_count;
    int    idle_cycles;

    rotation_matrix_to_quaternion_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .m00    (m00),
        .m01    (m01),
        .m02    (m02),
        .m10    (m10),
        .m11    (m11),
        .m12    (m12),
        .m20    (m20),
        .m21    (m21),
        .m22    (m22),
        .done   (done),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .quat_w (quat_w)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint div_root(longint num, longint unsigned root);
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        if (root == 0)
            return 0;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        mag = mag << FRAC;
        den = root << 1;
        q   = (2 * mag + den) / (2 * den);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic comp_t clip16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return comp_t'(-32768);
        return comp_t'(v);
    endfunction

    // Shepperd branch selection, then square root and three quotients.
    function automatic quat_t predict_quat(elem_t m [9]);
        longint a [9];
        longint one;
        longint trace;
        longint arg;
        longint unsigned root;
        longint half;
        longint qx, qy, qz, qw;
        quat_t r;
        for (int i = 0; i < 9; i++)
            a[i] = m[i];
        one   = longint'(1) << FRAC;
        trace = a[0] + a[4] + a[8];
        if (trace > 0)
            arg = trace + one;
        else if (a[0] > a[4] && a[0] > a[8])
            arg = one + a[0] - a[4] - a[8];
        else if (a[4] > a[8])
            arg = one + a[4] - a[0] - a[8];
        else
            arg = one + a[8] - a[0] - a[4];
        if (arg < 0)
            arg = 0;
        root = int_sqrt(longint'(arg) << FRAC);
        half = longint'((root + 1) >> 1);
        if (trace > 0)
        begin
            qw = half;
            qx = div_root(a[7] - a[5], root);
            qy = div_root(a[2] - a[6], root);
            qz = div_root(a[3] - a[1], root);
        end
        else if (a[0] > a[4] && a[0] > a[8])
        begin
            qx = half;
            qw = div_root(a[7] - a[5], root);
            qy = div_root(a[1] + a[3], root);
            qz = div_root(a[2] + a[6], root);
        end
        else if (a[4] > a[8])
        begin
            qy = half;
            qw = div_root(a[2] - a[6], root);
            qx = div_root(a[1] + a[3], root);
            qz = div_root(a[5] + a[7], root);
        end
        else
        begin
            qz = half;
            qw = div_root(a[3] - a[1], root);
            qx = div_root(a[2] + a[6], root);
            qy = div_root(a[5] + a[7], root);
        end
        r.x = clip16(qx);
        r.y = clip16(qy);
        r.z = clip16(qz);
        r.w = clip16(qw);
        return r;
    endfunction

    task automatic report_mismatch(string what, comp_t got, comp_t want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic add_expected(quat_t q);
        quat_queue.insert(quat_queue.size(), q);
    endtask

    task automatic add_dir(row_t r);
        dir.insert(dir.size(), r);
    endtask

    // Results cannot be held off, so every strobe is checked on the edge it ends.
    always @(posedge clk)
    begin
        quat_t e;
        if (rst_n && done)
        begin
            if (quat_queue.size() == 0)
            begin
                $display("unexpected quaternion at %0t", $time);
                error_count++;
            end
            else
            begin
                e = quat_queue.pop_front();
                if (quat_x !== e.x) report_mismatch("quat_x", quat_x, e.x);
                if (quat_y !== e.y) report_mismatch("quat_y", quat_y, e.y);
                if (quat_z !== e.z) report_mismatch("quat_z", quat_z, e.z);
                if (quat_w !== e.w) report_mismatch("quat_w", quat_w, e.w);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("FAIL rotation_matrix_to_quaternion_top");
            $finish;
        end
    end

    function automatic row_t make_row(elem_t d0, elem_t d1, elem_t d2,
                                      elem_t o01, elem_t o02, elem_t o10,
                                      elem_t o12, elem_t o20, elem_t o21);
        row_t r;
        r.m[0] = d0;  r.m[1] = o01; r.m[2] = o02;
        r.m[3] = o10; r.m[4] = d1;  r.m[5] = o12;
        r.m[6] = o20; r.m[7] = o21; r.m[8] = d2;
        r.has_exp = 1'b0;
        r.exp_q   = '0;
        return r;
    endfunction

    // Mostly random elements within +-1.0, some with a tied diagonal; also fully random noise and extremes.
    function automatic row_t random_row();
        row_t r;
        int   kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
        begin
            if (kind < 6)
                r.m[i] = elem_t'($signed($urandom_range(0, 32768)) - 16384);
            else if (kind < 8)
                r.m[i] = elem_t'($urandom);
            else
                r.m[i] = ($urandom_range(0, 1) ? 16'sh7fff : -16'sh8000);
        end
        if (kind == 5)
        begin
            r.m[4] = r.m[0];
            r.m[8] = r.m[0];
        end
        r.has_exp = 1'b0;
        r.exp_q   = '0;
        return r;
    endfunction

    task automatic send_row(row_t r);
        m00 <= r.m[0]; m01 <= r.m[1]; m02 <= r.m[2];
        m10 <= r.m[3]; m11 <= r.m[4]; m12 <= r.m[5];
        m20 <= r.m[6]; m21 <= r.m[7]; m22 <= r.m[8];
        start <= 1'b1;
        if (r.has_exp)
            add_expected(r.exp_q);
        else
            add_expected(predict_quat(r.m));
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic maybe_gap(ref int burst_left);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
        gap = $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        row_t r;
        int   burst_left;
        int   wait_cnt;
        error_count = 0;
        idle_cycles = 0;
        burst_left  = 0;
        rst_n = 1'b0;
        start = 1'b0;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;

        // Identity: w = 1.0, vector part zero.
        r = make_row(16384, 16384, 16384, 0, 0, 0, 0, 0, 0);
        r.has_exp = 1'b1; r.exp_q = '{x: 0, y: 0, z: 0, w: 16384};
        add_dir(r);
        // All zero: trace not positive, z branch with root 1.0 gives z = 0.5.
        r = make_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.has_exp = 1'b1; r.exp_q = '{x: 0, y: 0, z: 8192, w: 0};
        add_dir(r);
        // Opposite extremes on the diagonal with a positive trace.
        add_dir(make_row(-32768, 32767, 32767, 5, -7, 9, 11, -13, 15));
        // Rotations by 180 degrees about each axis.
        add_dir(make_row(16384, -16384, -16384, 0, 0, 0, 0, 0, 0));
        add_dir(make_row(-16384, 16384, -16384, 0, 0, 0, 0, 0, 0));
        add_dir(make_row(-16384, -16384, 16384, 0, 0, 0, 0, 0, 0));
        // Ties between diagonals.
        add_dir(make_row(-8000, -8000, -9000, 100, 200, 300, 400, 500, 600));
        add_dir(make_row(-8000, -9000, -8000, 100, 200, 300, 400, 500, 600));
        add_dir(make_row(-8000, -8000, -8000, 100, 200, 300, 400, 500, 600));
        // Extremes and saturation of the quotients.
        add_dir(make_row(32767, 32767, 32767, -32768, 32767, 32767,
                         -32768, -32768, 32767));
        add_dir(make_row(-32768, -32768, -32768, 32767, 32767, 32767,
                         32767, 32767, 32767));
        add_dir(make_row(1, 0, 0, -32768, -32768, -32768, -32768, -32768, -32768));
        add_dir(make_row(-16384, -16384, -32768, 32767, -32768, 32767,
                         32767, -32768, 32767));
        add_dir(make_row(32767, -32768, -32768, 32767, 32767, 32767,
                         32767, 32767, 32767));
        add_dir(make_row(-32768, 32767, -32768, -1, -1, -1, -1, -1, -1));
        add_dir(make_row(0, 0, 1, 0, 0, 0, 0, 0, 0));
        // A small rotation about z.
        add_dir(make_row(16000, 16000, 16384, -3500, 0, 3500, 0, 0, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i])
        begin
            send_row(dir[i]);
            maybe_gap(burst_left);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            send_row(random_row());
            if (n == N_RANDOM / 2)
            begin
                // Drain the pipeline completely before resuming.
                start <= 1'b0;
                while (quat_queue.size() != 0)
                    @(posedge clk);
            end
            else
                maybe_gap(burst_left);
        end
        start <= 1'b0;

        wait_cnt = 0;
        while (quat_queue.size() != 0 && wait_cnt < 10 * LATENCY)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (LATENCY) @(posedge clk);

        if (error_count == 0 && quat_queue.size() == 0)
            $display("PASS rotation_matrix_to_quaternion_top");
        else
            $display("FAIL rotation_matrix_to_quaternion_top");
        $finish;
    end

endmodule

// ===== rotation_matrix_to_quaternion_top.f =====
src/rmq_pkg.sv
src/rmq_sqrt.sv
src/rmq_div.sv
src/rotation_matrix_to_quaternion_top.sv
tb/rotation_matrix_to_quaternion_top_tb.sv
